FILE: rtl/bpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint and opcode trap unit: shared definitions
// Field widths, request codes and the classified request that moves from the
// front part to the back part.
// ----------------------------------------------------------------------------
package bpt_pkg;

	localparam int unsigned MAX_BP_DEFAULT = 16;
	localparam int unsigned TYPE_W         = 3;
	localparam int unsigned ADDR_W         = 16;
	localparam int unsigned OPC_W          = 8;
	localparam int unsigned ENTRIES_W      = 5;
	localparam int unsigned TRAP_ENTRIES   = 2 ** OPC_W;
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

	typedef enum logic [TYPE_W-1:0] {
		REQ_CHECK       = 3'd0,
		REQ_ADD         = 3'd1,
		REQ_REMOVE      = 3'd2,
		REQ_CLEAR_BPS   = 3'd3,
		REQ_SET_TRAP    = 3'd4,
		REQ_CLEAR_TRAP  = 3'd5,
		REQ_CLEAR_TRAPS = 3'd6,
		REQ_IGNORE      = 3'd7
	} req_op_t;

	typedef struct packed {
		req_op_t           op;
		logic              needs_scan;
		logic [ADDR_W-1:0] address;
		logic [OPC_W-1:0]  opcode;
	} req_t;

endpackage

FILE: rtl/breakpoint_and_opcode_trap_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint and opcode trap unit
// Requests enter on the req channel (req_valid, req_stall, req_type, address,
// opcode) and each gives exactly one result on the rsp channel (rsp_valid,
// rsp_stall, bp_hit, trap_hit, stop_run, entries_in_use, list_full), in order.
// A two-entry queue in the front part takes requests while the back part is
// busy; req_stall rises only when that queue is full.
// Check, add and remove scan the breakpoint list memory through its single
// read port, one entry per cycle. A remove then moves the later entries
// down, one per cycle. The back part carries out one request at a time and
// takes the next one from the queue in the cycle its result appears.
// Reset clears the count, the trap map, the queue and the result valid
// flag; list entries and result fields hold no defined value until
// written. While rsp_stall is high the result holds, the back part waits,
// and the queue keeps filling.
// ----------------------------------------------------------------------------
module breakpoint_and_opcode_trap_unit_top import bpt_pkg::*; #(
	parameter int unsigned MAX_BREAKPOINTS = MAX_BP_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [TYPE_W-1:0]    req_type,
	input  logic [ADDR_W-1:0]    address,
	input  logic [OPC_W-1:0]     opcode,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 bp_hit,
	output logic                 trap_hit,
	output logic                 stop_run,
	output logic [ENTRIES_W-1:0] entries_in_use,
	output logic                 list_full
);

	logic q_valid;
	req_t q_req;
	logic q_pop;

	bpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.address   (address),
		.opcode    (opcode),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop)
	);

	bpt_back #(
		.MAX_BREAKPOINTS (MAX_BREAKPOINTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_req          (q_req),
		.q_pop          (q_pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.bp_hit         (bp_hit),
		.trap_hit       (trap_hit),
		.stop_run       (stop_run),
		.entries_in_use (entries_in_use),
		.list_full      (list_full)
	);

endmodule

FILE: rtl/bpt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint and opcode trap unit: front part
// Accepts requests, classifies them and holds them in a short queue until the
// back part takes them.
// ----------------------------------------------------------------------------
module bpt_front import bpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [ADDR_W-1:0] address,
	input  logic [OPC_W-1:0]  opcode,
	output logic              q_valid,
	output req_t              q_req,
	input  logic              q_pop
);

	req_t              cls;
	req_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              full;
	logic              push;

	always_comb begin
		cls.address    = address;
		cls.opcode     = opcode;
		cls.needs_scan = 1'b0;
		unique case (req_type)
			REQ_CHECK: begin
				cls.op         = REQ_CHECK;
				cls.needs_scan = 1'b1;
			end
			REQ_ADD: begin
				cls.op         = REQ_ADD;
				cls.needs_scan = 1'b1;
			end
			REQ_REMOVE: begin
				cls.op         = REQ_REMOVE;
				cls.needs_scan = 1'b1;
			end
			REQ_CLEAR_BPS:   cls.op = REQ_CLEAR_BPS;
			REQ_SET_TRAP:    cls.op = REQ_SET_TRAP;
			REQ_CLEAR_TRAP:  cls.op = REQ_CLEAR_TRAP;
			REQ_CLEAR_TRAPS: cls.op = REQ_CLEAR_TRAPS;
			default:         cls.op = REQ_IGNORE;
		endcase
	end

	assign full      = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign push      = req_valid && !full;
	assign req_stall = full;
	assign q_valid   = (fill_q != '0);
	assign q_req     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + (QPTR_W + 1)'(1);
			end else if (q_pop && !push) begin
				fill_q <= fill_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

FILE: rtl/bpt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint and opcode trap unit: back part
// Carries out one request at a time: scans the breakpoint list memory one
// entry a cycle, closes gaps after a removal and keeps the trap map.
// ----------------------------------------------------------------------------
module bpt_back import bpt_pkg::*; #(
	parameter int unsigned MAX_BREAKPOINTS = MAX_BP_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  req_t                 q_req,
	output logic                 q_pop,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 bp_hit,
	output logic                 trap_hit,
	output logic                 stop_run,
	output logic [ENTRIES_W-1:0] entries_in_use,
	output logic                 list_full
);

	localparam int unsigned CNT_W = $clog2(MAX_BREAKPOINTS + 1);
	localparam int unsigned IDX_W = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BREAKPOINTS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	state_t                  state_q;
	req_t                    cur_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        scan_idx_q;
	logic [CNT_W-1:0]        rdi_q;
	logic                    rdv_q;
	logic [ADDR_W-1:0]       bp_mem [MAX_BREAKPOINTS];
	logic [ADDR_W-1:0]       rd_data_q;
	logic [TRAP_ENTRIES-1:0] trap_q;
	logic                    hit_q;
	logic                    trap_hit_q;
	logic                    full_q;
	logic                    out_valid_q;
	logic                    out_bp_q;
	logic                    out_trap_q;
	logic                    out_full_q;
	logic [ENTRIES_W-1:0]    out_cnt_q;

	logic                    match;
	logic                    issue;
	logic                    drained;
	logic                    out_free;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic [ADDR_W-1:0]       wr_data;
	logic [CNT_W-1:0]        shift_dst;

	assign match     = rdv_q && (rd_data_q == cur_q.address);
	assign issue     = ((state_q == ST_SCAN && !match) || state_q == ST_SHIFT)
	                   && (scan_idx_q < count_q);
	assign drained   = !issue && !rdv_q;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign shift_dst = rdi_q - CNT_ONE;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = cur_q.address;
		if (state_q == ST_SCAN && !match && drained && cur_q.op == REQ_ADD
		    && count_q < CNT_MAX) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
		end else if (state_q == ST_SHIFT && rdv_q) begin
			wr_en   = 1'b1;
			wr_addr = shift_dst[IDX_W-1:0];
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bp_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_q <= bp_mem[scan_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			rdi_q       <= '0;
			rdv_q       <= 1'b0;
			trap_q      <= '0;
			hit_q       <= 1'b0;
			trap_hit_q  <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_q <= issue;
			if (issue) begin
				rdi_q      <= scan_idx_q;
				scan_idx_q <= scan_idx_q + CNT_ONE;
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						hit_q      <= 1'b0;
						full_q     <= 1'b0;
						trap_hit_q <= (q_req.op == REQ_CHECK) && trap_q[q_req.opcode];
						scan_idx_q <= '0;
						state_q    <= q_req.needs_scan ? ST_SCAN : ST_RESP;
						unique case (q_req.op)
							REQ_CLEAR_BPS:   count_q <= '0;
							REQ_SET_TRAP:    trap_q[q_req.opcode] <= 1'b1;
							REQ_CLEAR_TRAP:  trap_q[q_req.opcode] <= 1'b0;
							REQ_CLEAR_TRAPS: trap_q <= '0;
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (match) begin
						priority if (cur_q.op == REQ_CHECK) begin
							hit_q   <= 1'b1;
							state_q <= ST_RESP;
						end else if (cur_q.op == REQ_REMOVE) begin
							scan_idx_q <= rdi_q + CNT_ONE;
							state_q    <= ST_SHIFT;
						end else begin
							state_q <= ST_RESP;
						end
					end else if (drained) begin
						if (cur_q.op == REQ_ADD) begin
							if (count_q < CNT_MAX) begin
								count_q <= count_q + CNT_ONE;
							end else begin
								full_q <= 1'b1;
							end
						end
						state_q <= ST_RESP;
					end
				end
				ST_SHIFT: begin
					if (drained) begin
						count_q <= count_q - CNT_ONE;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			out_bp_q   <= hit_q;
			out_trap_q <= trap_hit_q;
			out_full_q <= full_q;
			out_cnt_q  <= ENTRIES_W'(count_q);
		end
	end

	assign rsp_valid      = out_valid_q;
	assign bp_hit         = out_bp_q;
	assign trap_hit       = out_trap_q;
	assign stop_run       = out_bp_q | out_trap_q;
	assign list_full      = out_full_q;
	assign entries_in_use = out_cnt_q;

endmodule

FILE: rtl/bpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint and opcode trap unit: port checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bpt_checker import bpt_pkg::*; #(
	parameter int unsigned MAX_BREAKPOINTS = MAX_BP_DEFAULT
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input logic                 bp_hit,
	input logic                 trap_hit,
	input logic                 stop_run,
	input logic [ENTRIES_W-1:0] entries_in_use,
	input logic                 list_full
);

	a_stop_is_or: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (stop_run == (bp_hit || trap_hit)))
		else $error("stop_run differs from bp_hit or trap_hit");

	a_full_only_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && list_full |->
			!bp_hit && !trap_hit && entries_in_use == ENTRIES_W'(MAX_BREAKPOINTS))
		else $error("dropped add reported with hits or a list that is not full");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid
			&& $stable({bp_hit, trap_hit, stop_run, list_full, entries_in_use}))
		else $error("stalled result changed or was withdrawn");

endmodule

bind breakpoint_and_opcode_trap_unit_top bpt_checker #(
	.MAX_BREAKPOINTS (MAX_BREAKPOINTS)
) u_bpt_checker (.*);

FILE: tb/tb_breakpoint_and_opcode_trap_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the breakpoint and opcode trap unit
// Directed requests cover reset state, trap set and clear, filling the
// breakpoint list, duplicate and dropped adds, and removal with entry shift.
// Random traffic from small address and opcode pools then keeps the list
// near full. A local model of the list and trap map predicts every result.
// Each result is compared field by field, in order, while both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_breakpoint_and_opcode_trap_unit_top;
	import bpt_pkg::*;

	localparam int unsigned BP_SLOTS = MAX_BP_DEFAULT;
	localparam int unsigned STUCK_LIMIT = 5000;
	localparam int unsigned RANDOM_ITEMS = 1470;

	typedef struct packed {
		logic                 bp_hit;
		logic                 trap_hit;
		logic                 stop_run;
		logic [ENTRIES_W-1:0] entries;
		logic                 list_full;
	} trap_verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	logic [TYPE_W-1:0]    req_type;
	logic [ADDR_W-1:0]    address;
	logic [OPC_W-1:0]     opcode;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic                 bp_hit;
	logic                 trap_hit;
	logic                 stop_run;
	logic [ENTRIES_W-1:0] entries_in_use;
	logic                 list_full;

	logic [ADDR_W-1:0]       bp_table [BP_SLOTS];
	int                      bp_stored;
	bit [TRAP_ENTRIES-1:0]   trap_bits;
	trap_verdict_t           predicted_verdicts [$];
	int                      mismatch_count = 0;
	int                      send_burst_left;
	int                      stall_burst_left = 0;
	int                      stall_left = 0;
	int                      quiet_cycles = 0;

	breakpoint_and_opcode_trap_unit_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.address       (address),
		.opcode        (opcode),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.bp_hit        (bp_hit),
		.trap_hit      (trap_hit),
		.stop_run      (stop_run),
		.entries_in_use(entries_in_use),
		.list_full     (list_full)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int random_gap(inout int burst_left);
		int r;
		r = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if (r < 4) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic trap_verdict_t apply_debug_request(req_op_t op, logic [ADDR_W-1:0] addr,
			logic [OPC_W-1:0] opc);
		trap_verdict_t v;
		int found;
		int i;
		v = '0;
		found = -1;
		for (i = 0; i < bp_stored; i++) begin
			if (found < 0 && bp_table[i] == addr)
				found = i;
		end
		case (op)
			REQ_CHECK: begin
				v.bp_hit = (found >= 0);
				v.trap_hit = trap_bits[opc];
			end
			REQ_ADD: begin
				if (found < 0) begin
					if (bp_stored >= BP_SLOTS) begin
						v.list_full = 1'b1;
					end else begin
						bp_table[bp_stored] = addr;
						bp_stored++;
					end
				end
			end
			REQ_REMOVE: begin
				if (found >= 0) begin
					for (i = found; i < bp_stored - 1; i++)
						bp_table[i] = bp_table[i + 1];
					bp_stored--;
				end
			end
			REQ_CLEAR_BPS:   bp_stored = 0;
			REQ_SET_TRAP:    trap_bits[opc] = 1'b1;
			REQ_CLEAR_TRAP:  trap_bits[opc] = 1'b0;
			REQ_CLEAR_TRAPS: trap_bits = '0;
			default: ;
		endcase
		v.stop_run = v.bp_hit | v.trap_hit;
		v.entries = bp_stored[ENTRIES_W-1:0];
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_request(input req_op_t op, input logic [ADDR_W-1:0] addr,
			input logic [OPC_W-1:0] opc);
		int gap;
		gap = random_gap(send_burst_left);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= op;
		address <= addr;
		opcode <= opc;
		do @(posedge clk); while (req_stall);
		predicted_verdicts.push_back(apply_debug_request(op, addr, opc));
	endtask

	task automatic wait_for_all_results();
		req_valid <= 1'b0;
		while (predicted_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_after_reset();
		send_request(REQ_CHECK, 16'h0000, 8'h00);
		send_request(REQ_IGNORE, 16'hffff, 8'hff);
	endtask

	task automatic test_trap_set();
		send_request(REQ_SET_TRAP, 16'h0000, 8'hff);
		send_request(REQ_SET_TRAP, 16'hffff, 8'h00);
	endtask

	task automatic test_list_fill();
		int k;
		send_request(REQ_ADD, 16'h0000, 8'h00);
		send_request(REQ_ADD, 16'hffff, 8'h00);
		for (k = 1; k <= 14; k++)
			send_request(REQ_ADD, ADDR_W'(16'h1000 + k * 16'h0111), 8'($urandom));
		send_request(REQ_ADD, 16'hffff, 8'h00);
		send_request(REQ_ADD, 16'h8000, 8'h00);
		send_request(REQ_CHECK, 16'hffff, 8'hff);
	endtask

	task automatic test_remove_shift();
		send_request(REQ_REMOVE, 16'h1234, 8'h00);
		send_request(REQ_REMOVE, 16'h0000, 8'h00);
		send_request(REQ_CHECK, 16'h0000, 8'h00);
		send_request(REQ_CHECK, 16'h1eee, 8'h5a);
		send_request(REQ_CLEAR_TRAP, 16'h0000, 8'hff);
		send_request(REQ_CLEAR_TRAPS, 16'h0000, 8'h00);
		send_request(REQ_CLEAR_BPS, 16'h0000, 8'h00);
	endtask

	task automatic test_random_traffic();
		logic [ADDR_W-1:0] addr_pool [24];
		logic [OPC_W-1:0]  opc_pool [6];
		int                sent;
		int                r;
		req_op_t           op;
		logic [ADDR_W-1:0] a;
		logic [OPC_W-1:0]  o;
		foreach (addr_pool[k])
			addr_pool[k] = ADDR_W'($urandom);
		foreach (opc_pool[k])
			opc_pool[k] = OPC_W'($urandom);
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				op = REQ_CHECK;
			else if (r < 55)
				op = REQ_ADD;
			else if (r < 72)
				op = REQ_REMOVE;
			else if (r < 74)
				op = REQ_CLEAR_BPS;
			else if (r < 84)
				op = REQ_SET_TRAP;
			else if (r < 93)
				op = REQ_CLEAR_TRAP;
			else if (r < 95)
				op = REQ_CLEAR_TRAPS;
			else if (r < 98)
				op = REQ_IGNORE;
			else
				op = REQ_CHECK;
			a = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 23)]
				: ADDR_W'($urandom);
			o = ($urandom_range(0, 99) < 60) ? opc_pool[$urandom_range(0, 5)]
				: OPC_W'($urandom);
			send_request(op, a, o);
			if (op != REQ_IGNORE) begin
				sent++;
				if (sent == RANDOM_ITEMS / 2)
					wait_for_all_results();
			end
		end
	endtask

	always @(posedge clk) begin
		trap_verdict_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (predicted_verdicts.size() == 0) begin
				report_mismatch("unexpected result, entries_in_use", entries_in_use, -1);
			end else begin
				want = predicted_verdicts.pop_front();
				if (bp_hit !== want.bp_hit)
					report_mismatch("bp_hit", bp_hit, want.bp_hit);
				if (trap_hit !== want.trap_hit)
					report_mismatch("trap_hit", trap_hit, want.trap_hit);
				if (stop_run !== want.stop_run)
					report_mismatch("stop_run", stop_run, want.stop_run);
				if (entries_in_use !== want.entries)
					report_mismatch("entries_in_use", entries_in_use, want.entries);
				if (list_full !== want.list_full)
					report_mismatch("list_full", list_full, want.list_full);
			end
		end
	end

	always @(posedge clk) begin
		int gap;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			gap = random_gap(stall_burst_left);
			rsp_stall <= (gap > 0);
			stall_left = (gap > 0) ? gap - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STUCK_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = '0;
		address = '0;
		opcode = '0;
		bp_stored = 0;
		trap_bits = '0;
		send_burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_trap_set();
		test_list_fill();
		test_remove_shift();
		// Let the unit go fully idle before random requests start.
		wait_for_all_results();
		test_random_traffic();

		wait_for_all_results();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
